[hdl/bese_pkg.sv]
// Package for the bracket expression stack evaluator.
// Holds token and operator codes, status codes, the item structs and the
// command and status structs that join the controller and the datapath.
package bese_pkg;

	localparam int STACK_DEPTH = 64;

	localparam logic [2:0] KIND_NUMBER = 3'd0;
	localparam logic [2:0] KIND_PLUS   = 3'd1;
	localparam logic [2:0] KIND_TIMES  = 3'd2;
	localparam logic [2:0] KIND_OPEN   = 3'd3;
	localparam logic [2:0] KIND_CLOSE  = 3'd4;
	localparam logic [2:0] KIND_END    = 3'd5;

	localparam logic [1:0] OP_PLUS  = 2'd1;
	localparam logic [1:0] OP_TIMES = 2'd2;
	localparam logic [1:0] OP_OPEN  = 2'd3;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_EMPTY     = 2'd1;
	localparam logic [1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [1:0] ST_UNDERFLOW = 2'd3;

	typedef struct packed {
		logic [2:0]         kind;
		logic signed [31:0] number;
	} token_t;

	typedef struct packed {
		logic signed [31:0] answer;
		logic [1:0]         status;
	} result_t;

	typedef struct packed {
		logic push_val;
		logic push_op;
		logic pop_op;
		logic exec;
		logic set_under;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic       err_none;
		logic       ocnt_zero;
		logic       vcnt_lt2;
		logic [1:0] otop;
		logic       out_free;
	} sts_t;

endpackage

[hdl/bese_dpath.sv]
// Datapath of the bracket expression stack evaluator: value and operator
// stacks, their counts, the sticky error, the add and multiply unit and the
// result register. Depends on bese_pkg.
module bese_dpath #(
	parameter int STACK_DEPTH = bese_pkg::STACK_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bese_pkg::token_t  token,
	input  bese_pkg::cmd_t    cmd,
	output bese_pkg::sts_t    sts,
	output logic              result_valid,
	input  logic              result_ready,
	output bese_pkg::result_t result
);

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);

	logic [31:0]   vmem [STACK_DEPTH];
	logic [1:0]    omem [STACK_DEPTH];
	logic [CW-1:0] vcnt_q, ocnt_q;
	logic [1:0]    err_q, opc_q, otop_q;
	logic [31:0]   vtop_q, vnext_q;
	logic          result_valid_q;
	bese_pkg::result_t result_q;

	logic [CW-1:0] vcnt_m1, vcnt_m2, ocnt_m1;
	logic          v_full, o_full;
	logic          vwe;
	logic [AW-1:0] vwa;
	logic [31:0]   vwd, alu, prod;

	assign vcnt_m1 = vcnt_q - CW'(1);
	assign vcnt_m2 = vcnt_q - CW'(2);
	assign ocnt_m1 = ocnt_q - CW'(1);
	assign v_full  = vcnt_q == CW'(STACK_DEPTH);
	assign o_full  = ocnt_q == CW'(STACK_DEPTH);

	assign prod = 32'(vtop_q * vnext_q);
	assign alu  = (opc_q == bese_pkg::OP_TIMES) ? prod : vtop_q + vnext_q;

	assign vwe = (cmd.push_val && !v_full) || cmd.exec;
	assign vwa = cmd.exec ? vcnt_m2[AW-1:0] : vcnt_q[AW-1:0];
	assign vwd = cmd.exec ? alu : token.number;

	always_ff @(posedge clk) begin
		if (vwe) begin
			vmem[vwa] <= vwd;
		end
		vtop_q  <= vmem[vcnt_m1[AW-1:0]];
		vnext_q <= vmem[vcnt_m2[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.push_op && !o_full) begin
			omem[ocnt_q[AW-1:0]] <= token.kind[1:0];
		end
		otop_q <= omem[ocnt_m1[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (cmd.pop_op) begin
			opc_q <= otop_q;
		end
		if (cmd.emit) begin
			if (err_q != bese_pkg::ST_OK) begin
				result_q.answer <= '0;
				result_q.status <= err_q;
			end else if (vcnt_q == '0) begin
				result_q.answer <= '0;
				result_q.status <= bese_pkg::ST_EMPTY;
			end else begin
				result_q.answer <= vtop_q;
				result_q.status <= bese_pkg::ST_OK;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q         <= '0;
			ocnt_q         <= '0;
			err_q          <= bese_pkg::ST_OK;
			result_valid_q <= 1'b0;
		end else begin
			if (cmd.emit) begin
				vcnt_q <= '0;
				ocnt_q <= '0;
				err_q  <= bese_pkg::ST_OK;
			end else begin
				if (cmd.push_val) begin
					if (v_full) begin
						err_q <= bese_pkg::ST_OVERFLOW;
					end else begin
						vcnt_q <= vcnt_q + CW'(1);
					end
				end
				if (cmd.push_op) begin
					if (o_full) begin
						err_q <= bese_pkg::ST_OVERFLOW;
					end else begin
						ocnt_q <= ocnt_q + CW'(1);
					end
				end
				if (cmd.pop_op) begin
					ocnt_q <= ocnt_m1;
				end
				if (cmd.exec) begin
					vcnt_q <= vcnt_m1;
				end
				if (cmd.set_under) begin
					err_q <= bese_pkg::ST_UNDERFLOW;
				end
			end
			if (cmd.emit) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	assign sts.err_none  = err_q == bese_pkg::ST_OK;
	assign sts.ocnt_zero = ocnt_q == '0;
	assign sts.vcnt_lt2  = vcnt_q < CW'(2);
	assign sts.otop      = otop_q;
	assign sts.out_free  = !result_valid_q || result_ready;

	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule

[hdl/bese_ctrl.sv]
// Controller of the bracket expression stack evaluator: token handshake and
// the state machine that sequences bracket draining and end tokens.
// Depends on bese_pkg.
module bese_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           token_valid,
	input  logic [2:0]     kind,
	output logic           token_ready,
	input  bese_pkg::sts_t sts,
	output bese_pkg::cmd_t cmd
);

	typedef enum logic [4:0] {
		S_IDLE = 5'b00001,
		S_CHK  = 5'b00010,
		S_EXE  = 5'b00100,
		S_SYNC = 5'b01000,
		S_END  = 5'b10000
	} state_t;

	state_t state_q, state_nxt;
	logic   acc;

	assign token_ready = state_q == S_IDLE;
	assign acc         = token_valid && token_ready;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		case (state_q)
			S_IDLE: begin
				if (acc) begin
					if (kind == bese_pkg::KIND_END) begin
						state_nxt = S_END;
					end else if (sts.err_none) begin
						if (kind == bese_pkg::KIND_NUMBER) begin
							cmd.push_val = 1'b1;
						end else if (kind == bese_pkg::KIND_PLUS
								|| kind == bese_pkg::KIND_TIMES
								|| kind == bese_pkg::KIND_OPEN) begin
							cmd.push_op = 1'b1;
						end else if (kind == bese_pkg::KIND_CLOSE) begin
							state_nxt = S_CHK;
						end
					end
				end
			end
			S_CHK: begin
				if (sts.ocnt_zero) begin
					cmd.set_under = 1'b1;
					state_nxt     = S_IDLE;
				end else begin
					cmd.pop_op = 1'b1;
					if (sts.otop == bese_pkg::OP_OPEN) begin
						state_nxt = S_IDLE;
					end else if (sts.vcnt_lt2) begin
						cmd.set_under = 1'b1;
						state_nxt     = S_IDLE;
					end else begin
						state_nxt = S_EXE;
					end
				end
			end
			S_EXE: begin
				cmd.exec  = 1'b1;
				state_nxt = S_SYNC;
			end
			S_SYNC: begin
				state_nxt = S_CHK;
			end
			S_END: begin
				if (sts.out_free) begin
					cmd.emit  = 1'b1;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

[hdl/bracket_expression_stack_evaluator.sv]
// Number, operator and open-bracket tokens are handled as they are accepted.
// An end token holds off new tokens until the result register is free and
// loaded; a close bracket holds them off while it applies each operator down
// to its open bracket via S_CHK, S_EXE and S_SYNC, as stack reads are
// registered. Reset clears the stack counts, the error and the result valid
// flag at once; stack contents are not cleared and no clearing pass is needed.
module bracket_expression_stack_evaluator #(
	parameter int STACK_DEPTH = bese_pkg::STACK_DEPTH
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              token_valid,
	output logic              token_ready,
	input  bese_pkg::token_t  token,
	output logic              result_valid,
	input  logic              result_ready,
	output bese_pkg::result_t result
);

	bese_pkg::cmd_t cmd;
	bese_pkg::sts_t sts;

	bese_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.token_valid (token_valid),
		.kind        (token.kind),
		.token_ready (token_ready),
		.sts         (sts),
		.cmd         (cmd)
	);

	bese_dpath #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.token        (token),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

`ifndef SYNTHESIS
	a_emit_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> (!result_valid || result_ready))
		else $error("result overwritten before it was taken");

	a_exec_operands: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.exec |-> !sts.vcnt_lt2)
		else $error("operator applied with fewer than two values");

	a_close_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && token_ready && token.kind == bese_pkg::KIND_CLOSE
		&& sts.err_none) |=> !token_ready)
		else $error("close bracket did not start a drain");

	a_end_emits: assert property (@(posedge clk) disable iff (!arst_n)
		(token_valid && token_ready && token.kind == bese_pkg::KIND_END
		&& !result_valid) |=> cmd.emit)
		else $error("end token did not load a result");
`endif

endmodule
